@@ hdl/suhu_pkg.sv @@
// Shared constants and codes of the subset-sum universal hash unit.
package suhu_pkg;

	localparam int MAX_BITS       = 64;
	localparam int COEF_ONE_WIDTH = 32;
	localparam int COEF_TWO_WIDTH = 48;

	// fixed field widths
	localparam int MOD_ONE_W = 32;
	localparam int MOD_TWO_W = 48;
	localparam int CNT_W     = 7;
	localparam int POS_W     = 6;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 48;

	localparam int ADDR_W    = $clog2(MAX_BITS);
	localparam int IDX_W     = $clog2(MAX_BITS + 1);
	localparam int SUM_ONE_W = COEF_ONE_WIDTH + $clog2(MAX_BITS + 1);
	localparam int SUM_TWO_W = COEF_TWO_WIDTH + $clog2(MAX_BITS + 1);
	localparam int DIV_W     = (SUM_ONE_W > SUM_TWO_W) ? SUM_ONE_W : SUM_TWO_W;
	localparam int STEP_W    = $clog2(DIV_W + 1);

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_HASH  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_MODULUS_ONE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODULUS_TWO = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT   = 2'd2;

	typedef struct packed {
		logic                 start;
		logic [DIV_W-1:0]     dividend;
		logic [MOD_TWO_W-1:0] modulus;
	} mod_req_t;

endpackage

@@ hdl/suhu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module suhu_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hdl/suhu_mod.sv @@
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module suhu_mod (
	input  logic                          clk,
	input  logic                          arst_n,
	input  suhu_pkg::mod_req_t            req,
	output logic                          busy,
	output logic [suhu_pkg::MOD_TWO_W-1:0] remainder
);

	logic [suhu_pkg::MOD_TWO_W-1:0] rem_q;
	logic [suhu_pkg::DIV_W-1:0]     dvd_q;
	logic [suhu_pkg::MOD_TWO_W-1:0] mod_q;
	logic [suhu_pkg::STEP_W-1:0]    cnt_q;
	logic                           busy_q;
	logic [suhu_pkg::MOD_TWO_W:0]   trial;
	logic [suhu_pkg::MOD_TWO_W:0]   mod_ext;

	assign trial   = {rem_q, dvd_q[suhu_pkg::DIV_W-1]};
	assign mod_ext = {1'b0, mod_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= suhu_pkg::STEP_W'(suhu_pkg::DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - suhu_pkg::STEP_W'(1);
			if (cnt_q == suhu_pkg::STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// the remainder stays below the modulus, so the low bits of the
	// difference are exact
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			dvd_q <= req.dividend;
			mod_q <= req.modulus;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[suhu_pkg::DIV_W-2:0], 1'b0};
			if (trial >= mod_ext) begin
				rem_q <= trial[suhu_pkg::MOD_TWO_W-1:0] - mod_q;
			end else begin
				rem_q <= trial[suhu_pkg::MOD_TWO_W-1:0];
			end
		end
	end

	assign busy = busy_q;
	// a zero modulus reduces to zero
	assign remainder = (mod_q == '0) ? '0 : rem_q;

endmodule

@@ hdl/subset_sum_universal_hash_unit.sv @@
// Top level: coefficient memories, scan sequencer, reducers and output register.
// A write beat leaves the input unstalled; the next beat can follow at once. A hash beat holds
// the input stalled while the sequencer scans all 64 coefficient pairs (one read per cycle,
// registered read data, then the reducers start), the bit-serial remainder units run, and the
// output register loads (later while a result still waits there), so a new hash beat is taken
// only once the last result is loaded. Reset is asynchronous, active low; coefficient memories are not cleared.
module subset_sum_universal_hash_unit (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 command,
	input  logic [suhu_pkg::POS_W-1:0]           position,
	input  logic [31:0]                          coef_one,
	input  logic [47:0]                          coef_two,
	input  logic [63:0]                          bit_string,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [31:0]                          hash_one,
	output logic [47:0]                          hash_two,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [suhu_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [suhu_pkg::CFG_W-1:0]           cfg_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_MOD  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]                           state_q;
	logic [suhu_pkg::MOD_ONE_W-1:0]       modulus_one_q;
	logic [suhu_pkg::MOD_TWO_W-1:0]       modulus_two_q;
	logic [suhu_pkg::CNT_W-1:0]           bit_count_q;
	logic [suhu_pkg::IDX_W-1:0]           rd_idx_q;
	logic [suhu_pkg::MAX_BITS-1:0]        str_q;
	logic                                 valid_s1;
	logic                                 sel_s1;
	logic [suhu_pkg::SUM_ONE_W-1:0]       sum_one_q;
	logic [suhu_pkg::SUM_TWO_W-1:0]       sum_two_q;
	logic                                 out_valid_q;
	logic [31:0]                          hash_one_q;
	logic [47:0]                          hash_two_q;

	logic                                 accept;
	logic                                 wr_en;
	logic                                 rd_en;
	logic                                 scan_end;
	logic                                 out_free;
	logic [suhu_pkg::MAX_BITS-1:0]        lim_mask;
	logic [suhu_pkg::COEF_ONE_WIDTH-1:0]  rd_one;
	logic [suhu_pkg::COEF_TWO_WIDTH-1:0]  rd_two;
	suhu_pkg::mod_req_t                   req_one;
	suhu_pkg::mod_req_t                   req_two;
	logic                                 busy_one;
	logic                                 busy_two;
	logic [suhu_pkg::MOD_TWO_W-1:0]       rem_one;
	logic [suhu_pkg::MOD_TWO_W-1:0]       rem_two;

	assign in_stall  = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign wr_en     = accept && (command == suhu_pkg::CMD_WRITE) &&
		({1'b0, position} < suhu_pkg::CNT_W'(suhu_pkg::MAX_BITS));
	assign rd_en     = (state_q == ST_SCAN) &&
		(rd_idx_q != suhu_pkg::IDX_W'(suhu_pkg::MAX_BITS));
	assign scan_end  = (state_q == ST_SCAN) && !rd_en && !valid_s1;
	assign out_free  = !out_valid_q || !out_stall;

	// positions at or above the bit count drop out; a count above the
	// table depth saturates by itself
	always_comb begin
		for (int i = 0; i < suhu_pkg::MAX_BITS; i++) begin
			lim_mask[i] = (suhu_pkg::CNT_W'(i) < bit_count_q);
		end
	end

	suhu_ram #(
		.WIDTH(suhu_pkg::COEF_ONE_WIDTH),
		.DEPTH(suhu_pkg::MAX_BITS)
	) u_ram_one (
		.clk  (clk),
		.we   (wr_en),
		.waddr(position[suhu_pkg::ADDR_W-1:0]),
		.wdata(coef_one[suhu_pkg::COEF_ONE_WIDTH-1:0]),
		.re   (rd_en),
		.raddr(rd_idx_q[suhu_pkg::ADDR_W-1:0]),
		.rdata(rd_one)
	);

	suhu_ram #(
		.WIDTH(suhu_pkg::COEF_TWO_WIDTH),
		.DEPTH(suhu_pkg::MAX_BITS)
	) u_ram_two (
		.clk  (clk),
		.we   (wr_en),
		.waddr(position[suhu_pkg::ADDR_W-1:0]),
		.wdata(coef_two[suhu_pkg::COEF_TWO_WIDTH-1:0]),
		.re   (rd_en),
		.raddr(rd_idx_q[suhu_pkg::ADDR_W-1:0]),
		.rdata(rd_two)
	);

	assign req_one.start    = scan_end;
	assign req_one.dividend = suhu_pkg::DIV_W'(sum_one_q);
	assign req_one.modulus  = suhu_pkg::MOD_TWO_W'(modulus_one_q);
	assign req_two.start    = scan_end;
	assign req_two.dividend = suhu_pkg::DIV_W'(sum_two_q);
	assign req_two.modulus  = modulus_two_q;

	suhu_mod u_mod_one (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_one),
		.busy     (busy_one),
		.remainder(rem_one)
	);

	suhu_mod u_mod_two (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_two),
		.busy     (busy_two),
		.remainder(rem_two)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_one_q <= suhu_pkg::MOD_ONE_W'(2);
			modulus_two_q <= suhu_pkg::MOD_TWO_W'(2);
			bit_count_q   <= suhu_pkg::CNT_W'(64);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				suhu_pkg::REG_MODULUS_ONE: modulus_one_q <= cfg_data[suhu_pkg::MOD_ONE_W-1:0];
				suhu_pkg::REG_MODULUS_TWO: modulus_two_q <= cfg_data[suhu_pkg::MOD_TWO_W-1:0];
				suhu_pkg::REG_BIT_COUNT:   bit_count_q   <= cfg_data[suhu_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rd_idx_q    <= '0;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			if ((state_q == ST_OUT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept && (command == suhu_pkg::CMD_HASH)) begin
						state_q  <= ST_SCAN;
						rd_idx_q <= '0;
					end
				end
				ST_SCAN: begin
					if (rd_en) begin
						rd_idx_q <= rd_idx_q + suhu_pkg::IDX_W'(1);
					end
					if (scan_end) begin
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (!busy_one && !busy_two) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (command == suhu_pkg::CMD_HASH)) begin
			str_q     <= bit_string[suhu_pkg::MAX_BITS-1:0] & lim_mask;
			sum_one_q <= '0;
			sum_two_q <= '0;
		end else begin
			if (rd_en) begin
				str_q <= str_q >> 1;
			end
			// unselected entries may never have been written
			if (valid_s1 && sel_s1) begin
				sum_one_q <= sum_one_q + suhu_pkg::SUM_ONE_W'(rd_one);
				sum_two_q <= sum_two_q + suhu_pkg::SUM_TWO_W'(rd_two);
			end
		end
		sel_s1 <= str_q[0];
		if ((state_q == ST_OUT) && out_free) begin
			hash_one_q <= rem_one[31:0];
			hash_two_q <= rem_two;
		end
	end

	assign out_valid = out_valid_q;
	assign hash_one  = hash_one_q;
	assign hash_two  = hash_two_q;

endmodule

@@ hdl/suhu_chk.sv @@
// Port-level checker for the subset-sum universal hash unit, with its bind.
module suhu_chk (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           command,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [31:0]                    hash_one,
	input logic [47:0]                    hash_two
);

	// a held result beat keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hash_one) && $stable(hash_two))
		else $error("result beat changed while stalled");

	// a hash beat occupies the block
	a_hash_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (command == suhu_pkg::CMD_HASH) |=> in_stall)
		else $error("input not stalled after a hash beat");

	// a coefficient write takes a single beat
	a_write_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && (command == suhu_pkg::CMD_WRITE) |=> !in_stall)
		else $error("input stalled after a write beat");

	// a new result only comes out of hash work
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without a hash in flight");

endmodule

bind subset_sum_universal_hash_unit suhu_chk u_suhu_chk (.*);

@@ sim/hash_checker.sv @@
`timescale 1ns / 100ps
// Checker: tracks coefficient tables and registers, predicts each hash and compares results.
module hash_checker
	import suhu_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic                 command,
	input  logic [POS_W-1:0]     position,
	input  logic [31:0]          coef_one,
	input  logic [47:0]          coef_two,
	input  logic [63:0]          bit_string,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic [31:0]          hash_one,
	input  logic [47:0]          hash_two,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   pending,
	output int                   mismatches
);

	typedef struct packed {
		logic [31:0] one;
		logic [47:0] two;
	} hash_pair_t;

	logic [MOD_ONE_W-1:0] modulus_one;
	logic [MOD_TWO_W-1:0] modulus_two;
	logic [CNT_W-1:0]     bit_count;
	logic [31:0]          coef_table_one [MAX_BITS];
	logic [47:0]          coef_table_two [MAX_BITS];
	hash_pair_t           expected_hashes [$];
	hash_pair_t           want;

	function automatic hash_pair_t predict_hash(input logic [63:0] bits);
		logic [63:0] sum_one;
		logic [63:0] sum_two;
		int          span;
		hash_pair_t  pair;
		span = (bit_count > MAX_BITS) ? MAX_BITS : int'(bit_count);
		sum_one = '0;
		sum_two = '0;
		for (int i = 0; i < span; i++) begin
			if (bits[i]) begin
				sum_one += coef_table_one[i];
				sum_two += coef_table_two[i];
			end
		end
		// a zero modulus reads as zero, same as modulus one
		pair.one = (modulus_one == 0) ? '0 : 32'(sum_one % modulus_one);
		pair.two = (modulus_two == 0) ? '0 : 48'(sum_two % modulus_two);
		return pair;
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			modulus_one = 2;
			modulus_two = 2;
			bit_count = 64;
			mismatches = 0;
			expected_hashes.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_MODULUS_ONE: modulus_one = cfg_data[MOD_ONE_W-1:0];
					REG_MODULUS_TWO: modulus_two = cfg_data[MOD_TWO_W-1:0];
					REG_BIT_COUNT:   bit_count = cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				if (command == CMD_WRITE) begin
					coef_table_one[position] = coef_one;
					coef_table_two[position] = coef_two;
				end else begin
					expected_hashes.push_back(predict_hash(bit_string));
				end
			end
			if (out_valid && !out_stall) begin
				if (expected_hashes.size() == 0) begin
					$error("result beat with nothing expected: hash_one %0h hash_two %0h",
						hash_one, hash_two);
					mismatches++;
				end else begin
					want = expected_hashes.pop_front();
					if (hash_one !== want.one) begin
						$error("hash_one mismatch: expected %0h, got %0h", want.one, hash_one);
						mismatches++;
					end
					if (hash_two !== want.two) begin
						$error("hash_two mismatch: expected %0h, got %0h", want.two, hash_two);
						mismatches++;
					end
				end
			end
		end
		pending <= expected_hashes.size();
	end

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 100ps
// Testbench top: clock, reset, stimulus and verdict for the subset-sum hash unit.
module testbench;
	import suhu_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int DRAIN_CYCLES = 130;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic                 command;
	logic [POS_W-1:0]     position;
	logic [31:0]          coef_one;
	logic [47:0]          coef_two;
	logic [63:0]          bit_string;
	logic                 out_valid;
	logic                 out_stall;
	logic [31:0]          hash_one;
	logic [47:0]          hash_two;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int               pending_hashes;
	int               mismatch_count;
	int               cycle_count = 0;
	bit               calm = 1'b0;
	logic [63:0]      written = '0;
	logic [CNT_W-1:0] active_bits = 7'd64;

	always #5 clk = ~clk;

	subset_sum_universal_hash_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .position(position), .coef_one(coef_one),
		.coef_two(coef_two), .bit_string(bit_string),
		.out_valid(out_valid), .out_stall(out_stall),
		.hash_one(hash_one), .hash_two(hash_two),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	hash_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .position(position), .coef_one(coef_one),
		.coef_two(coef_two), .bit_string(bit_string),
		.out_valid(out_valid), .out_stall(out_stall),
		.hash_one(hash_one), .hash_two(hash_two),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.pending(pending_hashes), .mismatches(mismatch_count)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 11);
	endfunction

	// biased toward all-ones and zero so the sums hit their extremes
	function automatic logic [63:0] pick_value();
		case ($urandom_range(0, 7))
			0: return '1;
			1: return '0;
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic send_beat(input logic cmd, input logic [POS_W-1:0] pos,
		input logic [31:0] c1, input logic [47:0] c2, input logic [63:0] bits);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		position <= pos;
		coef_one <= c1;
		coef_two <= c2;
		bit_string <= bits;
		do @(posedge clk); while (in_stall);
		if (cmd == CMD_WRITE) begin
			written[pos] = 1'b1;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
	endtask

	task automatic set_config(input logic [31:0] m1, input logic [47:0] m2,
		input logic [CNT_W-1:0] bc);
		write_reg(REG_MODULUS_ONE, CFG_W'(m1));
		write_reg(REG_MODULUS_TWO, m2);
		write_reg(REG_BIT_COUNT, CFG_W'(bc));
		cfg_valid <= 1'b0;
		active_bits = bc;
	endtask

	// hold off the sender until all hashes are back, then let any write beat settle
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_hashes != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic random_item();
		logic [63:0] bits;
		logic [63:0] readable;
		int          span;
		span = (active_bits > MAX_BITS) ? MAX_BITS : int'(active_bits);
		readable = (span == 64) ? '1 : ((64'd1 << span) - 64'd1);
		if ($urandom_range(0, 9) < 3) begin
			send_beat(CMD_WRITE, POS_W'($urandom_range(0, 63)), 32'(pick_value()),
				48'(pick_value()), pick_value());
		end else begin
			case ($urandom_range(0, 3))
				0: bits = pick_value();
				1: bits = {$urandom, $urandom} & {$urandom, $urandom};
				2: bits = {$urandom, $urandom} | {$urandom, $urandom};
				default: bits = {$urandom, $urandom};
			endcase
			// selected bits may only reach entries already loaded
			send_beat(CMD_HASH, POS_W'($urandom), 32'(pick_value()), 48'(pick_value()),
				bits & (written | ~readable));
		end
	endtask

	// result side
	initial begin
		int gap;
		out_stall <= 1'b1;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				out_stall <= 1'b1;
				repeat (gap) @(posedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_WRITE;
		position <= '0;
		coef_one <= '0;
		coef_two <= '0;
		bit_string <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_MODULUS_ONE;
		cfg_data <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset register values first
		send_beat(CMD_WRITE, 6'd0, '1, '1, '0);
		send_beat(CMD_WRITE, 6'd1, 32'd1, 48'd1, '1);
		send_beat(CMD_WRITE, 6'd63, 32'h8000_0000, 48'h8000_0000_0000, '0);
		send_beat(CMD_HASH, '0, '0, '0, 64'h0);
		send_beat(CMD_HASH, '0, '0, '0, 64'h1);
		send_beat(CMD_HASH, '0, '0, '0, 64'h8000_0000_0000_0003);
		send_beat(CMD_HASH, '1, '1, '1, 64'h2);

		drain();
		set_config('1, '1, 7'd64);
		send_beat(CMD_HASH, '0, '0, '0, 64'h8000_0000_0000_0003);
		send_beat(CMD_HASH, '0, '0, '0, 64'h1);

		// zero bit count: nothing selected, any string is fine
		drain();
		set_config(32'd0, 48'd1, 7'd0);
		send_beat(CMD_HASH, '0, '0, '0, '1);

		// bit count past the table saturates
		drain();
		set_config(32'd1, 48'd0, 7'd127);
		send_beat(CMD_HASH, '0, '0, '0, 64'h8000_0000_0000_0003);

		drain();
		set_config(32'd3, 48'd5, 7'd1);
		send_beat(CMD_HASH, '0, '0, '0, '1);

		// load every entry, then mixed traffic under several register settings
		for (int p = 0; p < MAX_BITS; p++) begin
			send_beat(CMD_WRITE, POS_W'(p), 32'(pick_value()), 48'(pick_value()),
				pick_value());
		end
		for (int phase = 0; phase < 6; phase++) begin
			drain();
			calm = (phase == 2);
			case (phase)
				0: set_config('1, '1, 7'd64);
				1: set_config($urandom_range(2, 32'hFFFF_FFFF), 48'({$urandom, $urandom}),
					7'($urandom_range(0, 64)));
				2: set_config($urandom_range(2, 20), 48'($urandom_range(2, 20)), 7'd64);
				3: set_config($urandom, 48'({$urandom, $urandom}),
					7'($urandom_range(65, 127)));
				4: set_config($urandom, 48'({$urandom, $urandom}), 7'd64);
				default: set_config(32'hFFFF_FFFB, 48'hFFFF_FFFF_FFC5, 7'd63);
			endcase
			for (int k = 0; k < 60; k++) begin
				if (phase == 4 && k == 30) begin
					drain();
				end
				random_item();
			end
		end
		drain();

		if (mismatch_count == 0 && pending_hashes == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
